@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file spc_checker.sv
// no dependencies; take in with an include of the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define SPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never hold outside reset
`define SPC_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

@@ rtl/spc_pkg.sv @@
// shared types and constants of the stack permutation checker
// no dependencies; used by every design module of the block
`timescale 1ns / 1ps

package spc_pkg;

  // width of one sequence value, of the length register and of a target
  localparam int VAL_W = 7;

  // default number of stack cells
  localparam int MAX_LEN_DEF = 64;

  // reset value of the length register
  localparam logic [VAL_W-1:0] SEQ_LEN_RST = 7'd64;

  // register index as seen through the upper address bit
  localparam logic REG_SEQ_LEN = 1'b0;

  // control sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } st_e;

  // shift command broadcast to every stack cell
  typedef struct packed {
    logic push;
    logic pop;
  } stack_cmd_t;

endpackage

@@ rtl/spc_cell.sv @@
// one cell of the shifting stack: holds one value
// depends on spc_pkg for the value width and the shift command type
`timescale 1ns / 1ps

module spc_cell (
  input  logic                        clk_i,
  input  spc_pkg::stack_cmd_t         cmd_i,
  input  logic [spc_pkg::VAL_W-1:0]   from_up_i,
  input  logic [spc_pkg::VAL_W-1:0]   from_down_i,
  output logic [spc_pkg::VAL_W-1:0]   val_o
);
  import spc_pkg::*;

  logic [VAL_W-1:0] val_q;

  // push moves values away from the top, pop moves them towards it
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      val_q <= from_up_i;
    end else if (cmd_i.pop) begin
      val_q <= from_down_i;
    end
  end

  assign val_o = val_q;

endmodule

@@ rtl/spc_stack.sv @@
// stack built as a chain of spc_cell, cell 0 being the top
// depends on spc_pkg and spc_cell
`timescale 1ns / 1ps

module spc_stack #(
  parameter int DEPTH = spc_pkg::MAX_LEN_DEF
) (
  input  logic                        clk_i,
  input  spc_pkg::stack_cmd_t         cmd_i,
  input  logic [spc_pkg::VAL_W-1:0]   push_val_i,
  output logic [spc_pkg::VAL_W-1:0]   top_o
);
  import spc_pkg::*;

  logic [VAL_W-1:0] vals [DEPTH];

  // chain of cells, each linked to both neighbours
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] up;
    logic [VAL_W-1:0] down;

    if (i == 0) begin : g_top
      assign up = push_val_i;
    end else begin : g_mid
      assign up = vals[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      assign down = '0;
    end else begin : g_inner
      assign down = vals[i+1];
    end

    spc_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd_i),
      .from_up_i   (up),
      .from_down_i (down),
      .val_o       (vals[i])
    );
  end

  assign top_o = vals[0];

endmodule

@@ rtl/stack_permutation_checker.sv @@
// Stack permutation checker: streams target values in and says, item by
// item, whether the sequence can come from 1..n through one stack.
// Slave stream: s_axis_tdata_i[6:0] carries the target value. Master stream:
// one result per request, tdata bit 0 ok_so_far, bit 1 possible, tlast marks
// the result of the n-th item (the verdict); the sequence then restarts.
// APB port: one register, seq_length at byte address 0, reset value 64.
// Timing: a request is taken in the idle state and evaluated in the next cycle.
// The evaluation first pushes the fresh values that the item needs, one per
// cycle as the cell chain takes one push per cycle, and then takes a final
// step in which the result is registered; each value is pushed at most once.
// Results wait in one output register; a new request is taken while the
// previous result waits. If the receiver stalls with a result still held,
// the next item stops before its final step until the register frees.
// Reset: stack empty, next fresh value 1, no items seen, no failure, and
// seq_length back to 64. The stack cells themselves are not cleared.
`timescale 1ns / 1ps

module stack_permutation_checker #(
  parameter int MAX_LEN = spc_pkg::MAX_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [6:0] target_value, [7] zero
  // master stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [0] ok_so_far, [1] possible, [7:2] zero
  output logic        m_axis_tlast_o,   // done_res
  // configuration port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import spc_pkg::*;

  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int LEN_CAP = (MAX_LEN < (1 << VAL_W) - 1) ? MAX_LEN : (1 << VAL_W) - 1;

  st_e              state_q, state_d;
  logic [VAL_W-1:0] t_q;
  logic [VAL_W-1:0] seq_len_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [VAL_W:0]   fresh_q, fresh_d;
  logic [VAL_W-1:0] items_q, items_d;
  logic             failed_q, failed_d;
  logic             m_valid_q;
  logic             ok_q, done_q, poss_q;

  logic             out_load;
  logic             res_ok, res_done, res_poss;
  logic [VAL_W-1:0] n_eff;
  logic [VAL_W-1:0] top;
  logic             t_bad, hit, ge, need_push, fail_now;
  logic [CNT_W-1:0] count_after;
  stack_cmd_t       cmd;

  // configuration register
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == REG_SEQ_LEN) ? 32'(seq_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= SEQ_LEN_RST;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 paddr_i[2] == REG_SEQ_LEN) begin
      seq_len_q <= pwdata_i[VAL_W-1:0];
    end
  end

  // effective length, clamped to 1..LEN_CAP, the smaller of the stack depth and 127
  always_comb begin
    if (seq_len_q == '0) begin
      n_eff = VAL_W'(1);
    end else if (seq_len_q > VAL_W'(LEN_CAP)) begin
      n_eff = VAL_W'(LEN_CAP);
    end else begin
      n_eff = seq_len_q;
    end
  end

  // stack as a chain of cells
  spc_stack #(
    .DEPTH (MAX_LEN)
  ) u_stack (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .push_val_i (fresh_q[VAL_W-1:0]),
    .top_o      (top)
  );

  // decision terms for the held target
  assign t_bad     = (t_q == '0) || (t_q > n_eff);
  assign hit       = (count_q != '0) && (top == t_q);
  assign ge        = {1'b0, t_q} >= fresh_q;
  assign need_push = ge && (fresh_q < {1'b0, t_q});
  assign fail_now  = failed_q || t_bad || (!hit && !ge);

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // sequencer: push loop, then one final step per item
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    fresh_d     = fresh_q;
    items_d     = items_q;
    failed_d    = failed_q;
    cmd         = '0;
    out_load    = 1'b0;
    count_after = count_q;
    res_ok      = 1'b0;
    res_done    = 1'b0;
    res_poss    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!failed_q && !t_bad && !hit && need_push) begin
          // push one fresh value per cycle while the stack has room, else mark failure
          if (count_q < CNT_W'(MAX_LEN)) begin
            cmd.push = 1'b1;
            count_d  = count_q + CNT_W'(1);
          end else begin
            failed_d = 1'b1;
          end
          fresh_d = fresh_q + (VAL_W+1)'(1);
        end else if (!m_valid_q || m_axis_tready_i) begin
          // final step, result goes to the output register
          if (!failed_q && !t_bad && hit) begin
            cmd.pop     = 1'b1;
            count_after = count_q - CNT_W'(1);
          end
          if (!failed_q && !t_bad && !hit && ge) begin
            fresh_d = {1'b0, t_q} + (VAL_W+1)'(1);
          end
          res_ok   = !fail_now;
          res_done = ({1'b0, items_q} + (VAL_W+1)'(1)) >= {1'b0, n_eff};
          res_poss = res_done && !fail_now && (count_after == '0);
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (res_done) begin
            count_d  = '0;
            fresh_d  = (VAL_W+1)'(1);
            items_d  = '0;
            failed_d = 1'b0;
          end else begin
            count_d  = count_after;
            items_d  = items_q + VAL_W'(1);
            failed_d = fail_now;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      fresh_q   <= (VAL_W+1)'(1);
      items_q   <= '0;
      failed_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      fresh_q  <= fresh_d;
      items_q  <= items_d;
      failed_q <= failed_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      t_q <= s_axis_tdata_i[VAL_W-1:0];
    end
    if (out_load) begin
      ok_q   <= res_ok;
      done_q <= res_done;
      poss_q <= res_poss;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {6'b0, poss_q, ok_q};
  assign m_axis_tlast_o  = done_q;

endmodule

@@ rtl/spc_checker.sv @@
// port-level checks on the stack permutation checker, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  // a verdict of possible only comes on a final, failure-free result
  `SPC_NEVER(a_poss_final, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[1] && (!m_axis_tlast_o || !m_axis_tdata_o[0]), "possible without done and ok")

  // one item at a time: no request right after a taken one
  `SPC_ASSERT(a_one_item, clk_i, rst_ni, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o, "request taken while busy")

  // a new result appears only from the evaluation step
  `SPC_ASSERT(a_res_src, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o), "result without evaluation")

  // stalled result holds
  `SPC_ASSERT(a_hold, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)), "stalled result changed")

endmodule

bind stack_permutation_checker spc_checker u_spc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
